FILE: design/ssr_pkg.sv
package ssr_pkg;

    localparam int AXES = 4;
    localparam int AXW = 2;

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TARGET = 2'd0,
        REG_SCALE  = 2'd1,
        REG_MARGIN = 2'd2,
        REG_WATCH  = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  axis;
        logic [31:0] end_load;
        logic [31:0] jerk_load;
        logic [3:0]  neg_mask;
        logic [31:0] axis_steps;
        logic [7:0]  elapsed;
    } t_req;

    typedef struct packed {
        logic [31:0] delay;
        logic [31:0] speed;
        logic        regulating;
        logic [31:0] end_bound;
    } t_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } t_sqrt_req;

endpackage

FILE: design/ssr_if.sv
interface ssr_req_if;
    logic          valid;
    logic          ready;
    ssr_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ssr_rsp_if.sv
interface ssr_rsp_if;
    logic          valid;
    logic          ready;
    ssr_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ssr_delay.sv
// Computes scale / isqrt(value), scale when the root is zero, one bit per cycle.
module ssr_delay (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_sqrt_req i_req,
    input  logic [31:0]       i_scale,
    output logic              o_done,
    output logic [31:0]       o_delay
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SQRT = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_v, n_v;
    logic [31:0] r_res, n_res;
    logic [31:0] r_bit, n_bit;
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [32:0] w_sum;
    logic [32:0] w_shift;

    assign w_sum   = {1'b0, r_res} + {1'b0, r_bit};
    assign w_shift = {r_rem[31:0], r_q[31]};

    always_comb begin
        n_state = r_state;
        n_v = r_v;
        n_res = r_res;
        n_bit = r_bit;
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_v = i_req.value;
                    n_res = '0;
                    n_bit = 32'h4000_0000;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    if (r_res == '0) begin
                        n_q = i_scale;
                        n_done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_q = i_scale;
                        n_rem = '0;
                        n_cnt = 5'd31;
                        n_state = S_DIV;
                    end
                end else begin
                    if ({1'b0, r_v} >= w_sum) begin
                        n_v = r_v - w_sum[31:0];
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            S_DIV: begin
                if (w_shift >= {1'b0, r_res}) begin
                    n_rem = w_shift - {1'b0, r_res};
                    n_q = {r_q[30:0], 1'b1};
                end else begin
                    n_rem = w_shift;
                    n_q = {r_q[30:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
        end
        r_v <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done  = r_done;
    assign o_delay = r_q;

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state != S_IDLE)) else $error("done without work");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_IDLE))
        else $error("divide left wrongly");
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $countones(r_bit) <= 1) else $error("bad sqrt bit");
endmodule

FILE: design/stepper_speed_regulator_unit.sv
// Stepper speed regulator.
// Requests arrive on i_req (valid/ready): a sub-movement step, a load of one
// axis's end and jerk distances, or a start. Every request yields exactly one
// response on o_rsp with the step delay, speed distance, regulation flag and
// largest absolute end distance.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must do this while the block is idle, not enforced.
// A load, a start or an unused command presents its response after S_BOUND
// has scanned the axes in turn for the end bound. A sub-movement updates the
// axes in S_AXIS and decides in S_DEC, and responds from there when the speed
// is unchanged. A speed change runs the square root and divide unit in S_WAIT;
// when the root is zero the divide is skipped and the delay is the scale.
// One request is handled at a time; ready is low from acceptance until the
// response is taken, so a stalled receiver holds the response and the block.
// With a ready receiver the block goes from S_RESP back to S_IDLE, where the
// next request is accepted.
// Reset clears all distances, speed, delay and flags; increasing resets to one.
module stepper_speed_regulator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssr_req_if.sink     i_req,
    ssr_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_AXIS  = 6'b000010,
        S_DEC   = 6'b000100,
        S_WAIT  = 6'b001000,
        S_RESP  = 6'b010000,
        S_BOUND = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    ssr_pkg::t_req r_req, n_req;
    logic [31:0]   r_end [ssr_pkg::AXES];
    logic [31:0]   r_jerk [ssr_pkg::AXES];
    logic [31:0]   n_end_w, n_jerk_w;
    logic          w_wr;
    logic [ssr_pkg::AXW-1:0] r_ax, n_ax;
    logic [31:0]   r_eb, n_eb, r_jm, n_jm;
    logic [31:0]   r_speed, n_speed, r_delay, n_delay;
    logic          r_en, n_en, r_inc, n_inc, r_skip, n_skip;
    logic [31:0]   r_target, r_scale, r_margin;
    logic          r_watch;
    logic          r_valid, n_valid;
    ssr_pkg::t_sqrt_req w_sq;
    logic          w_sq_done;
    logic [31:0]   w_sq_delay;
    logic [31:0]   w_cnt, w_e, w_j, w_ea, w_ja, w_jb;
    logic [32:0]   w_jsum, w_up;
    logic          w_slow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_scale <= '0;
            r_margin <= '0;
            r_watch <= 1'b0;
        end else if (i_cfg_we) begin
            case (ssr_pkg::t_reg'(i_cfg_idx))
                ssr_pkg::REG_TARGET: r_target <= i_cfg_data;
                ssr_pkg::REG_SCALE:  r_scale <= i_cfg_data;
                ssr_pkg::REG_MARGIN: r_margin <= i_cfg_data;
                ssr_pkg::REG_WATCH:  r_watch <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ssr_delay u_delay (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_sq), .i_scale(r_scale),
        .o_done(w_sq_done), .o_delay(w_sq_delay)
    );

    assign w_cnt = {24'd0, r_req.axis_steps[8*r_ax +: 8]};
    assign w_e = r_req.neg_mask[r_ax] ? r_end[r_ax] + w_cnt : r_end[r_ax] - w_cnt;
    assign w_j = r_req.neg_mask[r_ax] ? r_jerk[r_ax] + w_cnt : r_jerk[r_ax] - w_cnt;
    assign w_ea = (r_state == S_AXIS) ? (w_e[31] ? 32'd0 - w_e : w_e)
                : (r_end[r_ax][31] ? 32'd0 - r_end[r_ax] : r_end[r_ax]);
    assign w_ja = w_j[31] ? 32'd0 - w_j : w_j;
    assign w_jsum = {1'b0, r_jm} + {1'b0, r_margin};
    assign w_jb = w_jsum[32] ? 32'hFFFF_FFFF : w_jsum[31:0];
    assign w_up = {1'b0, r_speed} + {24'd0, r_req.elapsed};
    assign w_slow = r_delay > r_target;

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_ax = r_ax;
        n_eb = r_eb;
        n_jm = r_jm;
        n_speed = r_speed;
        n_delay = r_delay;
        n_en = r_en;
        n_inc = r_inc;
        n_skip = r_skip;
        n_valid = r_valid;
        w_wr = 1'b0;
        n_end_w = w_e;
        n_jerk_w = w_j;
        w_sq.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.payload;
                    n_ax = '0;
                    n_eb = '0;
                    n_jm = '0;
                    case (ssr_pkg::t_cmd'(i_req.payload.cmd))
                        ssr_pkg::CMD_STEP: n_state = S_AXIS;
                        ssr_pkg::CMD_LOAD: n_state = S_BOUND;
                        ssr_pkg::CMD_START: begin
                            n_en = 1'b1;
                            if (r_speed == '0) n_delay = r_scale;
                            n_state = S_BOUND;
                        end
                        default: n_state = S_BOUND;
                    endcase
                    if (i_req.payload.cmd == ssr_pkg::CMD_LOAD) begin
                        w_wr = 1'b1;
                        n_end_w = i_req.payload.end_load;
                        n_jerk_w = i_req.payload.jerk_load;
                    end
                end
            end
            S_AXIS: begin
                w_wr = 1'b1;
                if (w_ea > r_eb) n_eb = w_ea;
                if (w_ja > r_jm) n_jm = w_ja;
                n_ax = r_ax + 1'b1;
                if (r_ax == ssr_pkg::AXW'(ssr_pkg::AXES - 1)) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_RESP;
                if (r_eb < r_speed || (r_watch && w_jb < r_speed)) begin
                    n_speed = (r_eb < r_speed) ? r_eb : w_jb;
                    n_en = 1'b1;
                    n_inc = 1'b1;
                    n_skip = 1'b1;
                    n_state = S_WAIT;
                end else if (r_en) begin
                    if (r_skip) begin
                        n_skip = 1'b0;
                    end else if (w_slow != r_inc) begin
                        n_delay = r_target;
                        n_en = 1'b0;
                    end else if (w_slow) begin
                        n_speed = w_up[32] ? 32'hFFFF_FFFF : w_up[31:0];
                        n_inc = 1'b1;
                        n_state = S_WAIT;
                    end else begin
                        n_speed = (r_speed < {24'd0, r_req.elapsed}) ? 32'd0
                                : r_speed - {24'd0, r_req.elapsed};
                        n_inc = 1'b0;
                        n_state = S_WAIT;
                    end
                end
                if (n_state == S_WAIT) w_sq.start = 1'b1;
                else n_valid = 1'b1;
            end
            S_WAIT: begin
                if (w_sq_done) begin
                    n_delay = w_sq_delay;
                    n_valid = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_BOUND: begin
                if (w_ea > r_eb) n_eb = w_ea;
                n_ax = r_ax + 1'b1;
                if (r_ax == ssr_pkg::AXW'(ssr_pkg::AXES - 1)) begin
                    n_valid = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        w_sq.value = n_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_speed <= '0;
            r_delay <= '0;
            r_en <= 1'b0;
            r_inc <= 1'b1;
            r_skip <= 1'b0;
            r_valid <= 1'b0;
            for (int i = 0; i < ssr_pkg::AXES; i++) begin
                r_end[i] <= '0;
                r_jerk[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_speed <= n_speed;
            r_delay <= n_delay;
            r_en <= n_en;
            r_inc <= n_inc;
            r_skip <= n_skip;
            r_valid <= n_valid;
            if (w_wr) begin
                if (r_state == S_IDLE) begin
                    r_end[i_req.payload.axis] <= n_end_w;
                    r_jerk[i_req.payload.axis] <= n_jerk_w;
                end else begin
                    r_end[r_ax] <= n_end_w;
                    r_jerk[r_ax] <= n_jerk_w;
                end
            end
        end
        r_req <= n_req;
        r_ax <= n_ax;
        r_eb <= n_eb;
        r_jm <= n_jm;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_valid;
    assign o_rsp.payload.delay = r_delay;
    assign o_rsp.payload.speed = r_speed;
    assign o_rsp.payload.regulating = r_en;
    assign o_rsp.payload.end_bound = r_eb;

    a_valid_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_RESP)) else $error("response outside state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |=> r_valid && $stable(r_speed))
        else $error("response dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_skip_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skip) |-> r_en) else $error("skip without regulation");
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    ssr_req_if req_ch ();
    ssr_rsp_if rsp_ch ();

    stepper_speed_regulator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0] p_target, p_scale, p_margin;
    logic        p_watch;
    logic [31:0] p_end [ssr_pkg::AXES];
    logic [31:0] p_jerk [ssr_pkg::AXES];
    logic [31:0] p_speed, p_delay;
    logic        p_enabled, p_increasing, p_skip;

    ssr_pkg::t_rsp expected_rsp_q[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   sink_hold = 1'b0;

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [31:0] largest_end();
        logic [31:0] best;
        best = 0;
        for (int i = 0; i < ssr_pkg::AXES; i++)
            if (magnitude(p_end[i]) > best) best = magnitude(p_end[i]);
        return best;
    endfunction

    function automatic logic [31:0] root_floor(logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--)
            if (64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b)) <= 64'(v))
                r = r | (32'd1 << b);
        return r;
    endfunction

    task automatic apply_speed(logic [31:0] s);
        logic [31:0] r;
        p_speed = s;
        r = root_floor(s);
        p_delay = (r == 0) ? p_scale : p_scale / r;
    endtask

    task automatic clamp_speed(logic [31:0] bound);
        apply_speed(bound);
        p_enabled = 1'b1;
        p_increasing = 1'b1;
        p_skip = 1'b1;
    endtask

    task automatic predict_rsp(ssr_pkg::t_req r, output ssr_pkg::t_rsp res);
        logic [31:0] eb, jm, jb, n;
        logic        slow;
        case (ssr_pkg::t_cmd'(r.cmd))
            ssr_pkg::CMD_STEP: begin
                for (int i = 0; i < ssr_pkg::AXES; i++) begin
                    n = 32'(r.axis_steps[8*i +: 8]);
                    if (r.neg_mask[i]) begin
                        p_end[i] += n;
                        p_jerk[i] += n;
                    end else begin
                        p_end[i] -= n;
                        p_jerk[i] -= n;
                    end
                end
                eb = largest_end();
                jm = 0;
                for (int i = 0; i < ssr_pkg::AXES; i++)
                    if (magnitude(p_jerk[i]) > jm) jm = magnitude(p_jerk[i]);
                jb = (jm > 32'hFFFF_FFFF - p_margin) ? 32'hFFFF_FFFF : jm + p_margin;
                if (eb < p_speed) begin
                    clamp_speed(eb);
                end else if (p_watch && jb < p_speed) begin
                    clamp_speed(jb);
                end else if (p_enabled) begin
                    if (p_skip) begin
                        p_skip = 1'b0;
                    end else begin
                        slow = p_delay > p_target;
                        if (slow != p_increasing) begin
                            p_delay = p_target;
                            p_enabled = 1'b0;
                        end else if (slow) begin
                            apply_speed((p_speed > 32'hFFFF_FFFF - 32'(r.elapsed)) ?
                                        32'hFFFF_FFFF : p_speed + 32'(r.elapsed));
                            p_increasing = 1'b1;
                        end else begin
                            apply_speed((p_speed < 32'(r.elapsed)) ?
                                        32'd0 : p_speed - 32'(r.elapsed));
                            p_increasing = 1'b0;
                        end
                    end
                end
            end
            ssr_pkg::CMD_LOAD: begin
                p_end[r.axis] = r.end_load;
                p_jerk[r.axis] = r.jerk_load;
            end
            ssr_pkg::CMD_START: begin
                p_enabled = 1'b1;
                if (p_speed == 0) p_delay = p_scale;
            end
            default: ;
        endcase
        res.delay = p_delay;
        res.speed = p_speed;
        res.regulating = p_enabled;
        res.end_bound = largest_end();
    endtask

    task automatic write_register(ssr_pkg::t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ssr_pkg::REG_TARGET: p_target = value;
            ssr_pkg::REG_SCALE:  p_scale = value;
            ssr_pkg::REG_MARGIN: p_margin = value;
            default:             p_watch = value[0];
        endcase
    endtask

    task automatic configure(logic [31:0] target, logic [31:0] scale,
                             logic [31:0] margin, logic watch);
        write_register(ssr_pkg::REG_TARGET, target);
        write_register(ssr_pkg::REG_SCALE, scale);
        write_register(ssr_pkg::REG_MARGIN, margin);
        write_register(ssr_pkg::REG_WATCH, {31'd0, watch});
    endtask

    function automatic int gap_length();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    endfunction

    // Sends one request; a non-empty typed answer is also checked against the predictor.
    task automatic send_request(ssr_pkg::t_req r, bit has_fixed, ssr_pkg::t_rsp fixed,
                                bit idle_ok);
        ssr_pkg::t_rsp res;
        int gap;
        gap = idle_ok ? gap_length() : 0;
        repeat (gap + 1) @(negedge i_clk);
        predict_rsp(r, res);
        if (has_fixed && res !== fixed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row mismatch: typed %h predicted %h", fixed, res);
        end
        expected_rsp_q.push_back(res);
        req_ch.payload <= r;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_rsp_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic ssr_pkg::t_req make_req(ssr_pkg::t_cmd c, logic [1:0] ax,
                                               logic [31:0] e, logic [31:0] j,
                                               logic [3:0] m, logic [31:0] s,
                                               logic [7:0] el);
        ssr_pkg::t_req r;
        r.cmd = c;
        r.axis = ax;
        r.end_load = e;
        r.jerk_load = j;
        r.neg_mask = m;
        r.axis_steps = s;
        r.elapsed = el;
        return r;
    endfunction

    function automatic ssr_pkg::t_req random_req(bit well_formed);
        ssr_pkg::t_req r;
        int pick;
        r = ssr_pkg::t_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (!well_formed) return r;
        if (pick < 8) begin
            r.cmd = ssr_pkg::CMD_LOAD;
            if ($urandom_range(0, 3) != 0) begin
                r.end_load = $urandom_range(0, 20000) - 10000;
                r.jerk_load = $urandom_range(0, 20000) - 10000;
            end
        end else if (pick < 12) begin
            r.cmd = ssr_pkg::CMD_START;
        end else begin
            r.cmd = ssr_pkg::CMD_STEP;
            if ($urandom_range(0, 1)) r.axis_steps = $urandom & 32'h0303_0303;
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0) ||
                            ($urandom_range(0, 40) == 0 ? 1'b0 : 1'b1) && $urandom_range(0, 1);
        end
    end

    always @(posedge i_clk) begin
        ssr_pkg::t_rsp want;
        cycles <= cycles + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", rsp_ch.payload);
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_ch.payload.delay !== want.delay ||
                    rsp_ch.payload.speed !== want.speed ||
                    rsp_ch.payload.regulating !== want.regulating ||
                    rsp_ch.payload.end_bound !== want.end_bound) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %h actual %h", want,
                                 rsp_ch.payload);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    typedef struct {
        ssr_pkg::t_req req;
        bit            fixed;
        ssr_pkg::t_rsp rsp;
    } t_row;

    t_row rows[$];

    initial begin
        ssr_pkg::t_rsp none;
        none = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        p_target = 0;
        p_scale = 0;
        p_margin = 0;
        p_watch = 0;
        for (int i = 0; i < ssr_pkg::AXES; i++) begin
            p_end[i] = 0;
            p_jerk[i] = 0;
        end
        p_speed = 0;
        p_delay = 0;
        p_enabled = 0;
        p_increasing = 1;
        p_skip = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back('{make_req(ssr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0), 1,
                         ssr_pkg::t_rsp'({32'd0, 32'd0, 1'b0, 32'd0})});
        rows.push_back('{make_req(ssr_pkg::CMD_NONE, 3, '1, '1, 4'hF, '1, 8'hFF), 1,
                         ssr_pkg::t_rsp'({32'd0, 32'd0, 1'b0, 32'd0})});
        rows.push_back('{make_req(ssr_pkg::CMD_LOAD, 0, 32'h8000_0000, 32'h8000_0000,
                                  0, 0, 0), 1,
                         ssr_pkg::t_rsp'({32'd0, 32'd0, 1'b0, 32'h8000_0000})});
        rows.push_back('{make_req(ssr_pkg::CMD_LOAD, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  0, 0, 0), 0, none});
        rows.push_back('{make_req(ssr_pkg::CMD_STEP, 0, 0, 0, 4'hF, 32'hFFFF_FFFF, 8'hFF),
                         0, none});
        rows.push_back('{make_req(ssr_pkg::CMD_STEP, 0, 0, 0, 4'h0, 32'hFFFF_FFFF, 8'h00),
                         0, none});
        rows.push_back('{make_req(ssr_pkg::CMD_START, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_req(ssr_pkg::CMD_LOAD, 1, 32'd100, 32'd50, 0, 0, 0), 0, none});
        for (int i = 0; i < 12; i++)
            rows.push_back('{make_req(ssr_pkg::CMD_STEP, 0, 0, 0, 4'h5, 32'h0102_0304, 8'hFF),
                             0, none});
        for (int ax = 0; ax < ssr_pkg::AXES; ax++)
            rows.push_back('{make_req(ssr_pkg::CMD_LOAD, 2'(ax), 32'd5, 32'd5, 0, 0, 0),
                             0, none});
        rows.push_back('{make_req(ssr_pkg::CMD_STEP, 0, 0, 0, 4'hA, 32'h1010_1010, 8'd40),
                         0, none});

        configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        foreach (rows[k]) send_request(rows[k].req, rows[k].fixed, rows[k].rsp, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: configure(32'd500, 32'd100000, 32'd0, 1'b1);
                1: configure(32'hFFFF_FFFF, 32'd0, 32'd100, 1'b1);
                2: configure(32'd20, 32'hFFFF_FFFF, 32'd50, 1'b0);
                3: configure($urandom, $urandom, $urandom_range(0, 1000), 1'b1);
                default: configure(32'd3000, 32'd1000000, 32'hFFFF_FFF0, 1'b1);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if (n == 100) begin
                    while (expected_rsp_q.size() != 0) @(negedge i_clk);
                    sink_hold = (phase == 2);
                    repeat (30) @(negedge i_clk);
                    sink_hold = 1'b0;
                end
                send_request(random_req($urandom_range(0, 9) != 0), 1'b0, none,
                             $urandom_range(0, 4) != 0 || n > 200);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
